// ===== sv/pfe_pkg.sv =====
// Package: shared types and constants for the polynomial feature expansion block.
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

   // Field widths fixed by the interface
   localparam int SAMPLE_W   = 16;
   localparam int VALUE_W    = 48;
   localparam int FEAT_IDX_W = 6;
   localparam int DEGREE_W   = 2;
   localparam int ROW_LEN_W  = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Constant feature, 1.0 in Q12.36
   localparam logic [VALUE_W-1:0] CONST_FEATURE = 48'h0010_0000_0000;

   // Register reset values
   localparam logic [DEGREE_W-1:0]  DEGREE_RESET     = 2'd3;
   localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RESET = 3'd5;

   // Register index, taken from the word address bit of the APB address
   localparam logic CSR_IDX_DEGREE     = 1'b0;
   localparam logic CSR_IDX_ROW_LENGTH = 1'b1;

   // Degree codes
   localparam logic [DEGREE_W-1:0] DEG_CONST  = 2'd0;
   localparam logic [DEGREE_W-1:0] DEG_LINEAR = 2'd1;
   localparam logic [DEGREE_W-1:0] DEG_QUAD   = 2'd2;
   localparam logic [DEGREE_W-1:0] DEG_CUBIC  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONST,
      ST_LIN,
      ST_QJ,
      ST_QK,
      ST_CJ,
      ST_CK,
      ST_CM
   } pfe_state_type;

   typedef enum logic [1:0] {
      VAL_CONST,
      VAL_LIN,
      VAL_QUAD,
      VAL_CUBE
   } pfe_val_sel_type;

   typedef struct packed {
      logic                  wr_en;
      logic                  load_xj;
      logic                  load_pjk;
      logic                  emit;
      pfe_val_sel_type       sel;
      logic [FEAT_IDX_W-1:0] index;
      logic                  last;
   } pfe_cmd_type;

endpackage

`default_nettype wire

// ===== sv/pfe_ctrl.sv =====
// Controller: row fill counting and the feature emission sequencer.
`timescale 1ns / 1ps
`default_nettype none

module pfe_ctrl
   import pfe_pkg::*;
#(
   parameter int MAX_ROW_LENGTH = 5
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_valid,
   input  wire logic [DEGREE_W-1:0]               cfg_degree,
   input  wire logic [ROW_LEN_W-1:0]              cfg_row_length,
   output pfe_cmd_type                            cmd,
   output logic [((MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1)-1:0] wr_addr,
   output logic [((MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1)-1:0] rd_addr
);

   localparam int IDX_W = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
   localparam int CNT_W = $clog2(MAX_ROW_LENGTH + 1);

   pfe_state_type         state_ff, state_in;
   logic [IDX_W-1:0]      j_ff, j_in, k_ff, k_in, m_ff, m_in;
   logic [FEAT_IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      len_ff, len_in;
   logic [DEGREE_W-1:0]   deg_ff, deg_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0] len_now;
   logic [CNT_W-1:0] count_base;
   logic [CNT_W-1:0] count_next;
   logic [IDX_W-1:0] lm1;
   logic             out_free;

   // Clamp the row length into 1..MAX_ROW_LENGTH
   always_comb begin
      if (cfg_row_length == '0) begin
         len_now = CNT_W'(1);
      end else if (cfg_row_length > ROW_LEN_W'(MAX_ROW_LENGTH)) begin
         len_now = CNT_W'(MAX_ROW_LENGTH);
      end else begin
         len_now = CNT_W'(cfg_row_length);
      end
   end

   assign count_base = (count_ff >= len_now) ? '0 : count_ff;
   assign count_next = count_base + 1'b1;
   assign wr_addr    = IDX_W'(count_base);
   assign lm1        = IDX_W'(len_ff - 1'b1);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         j_ff         <= '0;
         k_ff         <= '0;
         m_ff         <= '0;
         idx_ff       <= '0;
         count_ff     <= '0;
         len_ff       <= CNT_W'(1);
         deg_ff       <= DEG_CONST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         m_ff         <= m_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         deg_ff       <= deg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      m_in         = m_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      deg_in       = deg_ff;
      req_ready    = 1'b0;
      rd_addr      = j_ff;
      cmd.wr_en    = 1'b0;
      cmd.load_xj  = 1'b0;
      cmd.load_pjk = 1'b0;
      cmd.emit     = 1'b0;
      cmd.sel      = VAL_CONST;
      cmd.index    = idx_ff;
      cmd.last     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.wr_en = 1'b1;
               if (count_next == len_now) begin
                  count_in = '0;
                  len_in   = len_now;
                  deg_in   = cfg_degree;
                  idx_in   = '0;
                  j_in     = '0;
                  state_in = ST_CONST;
               end else begin
                  count_in = count_next;
               end
            end
         end
         ST_CONST: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = VAL_CONST;
               cmd.last = (deg_ff == DEG_CONST);
               idx_in   = idx_ff + 1'b1;
               j_in     = '0;
               state_in = (deg_ff == DEG_CONST) ? ST_IDLE : ST_LIN;
            end
         end
         ST_LIN: begin
            rd_addr = j_ff;
            if (out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = VAL_LIN;
               cmd.last = (deg_ff == DEG_LINEAR) && (j_ff == lm1);
               idx_in   = idx_ff + 1'b1;
               if (j_ff == lm1) begin
                  j_in     = '0;
                  state_in = (deg_ff == DEG_LINEAR) ? ST_IDLE : ST_QJ;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         ST_QJ: begin
            rd_addr     = j_ff;
            cmd.load_xj = 1'b1;
            k_in        = '0;
            state_in    = ST_QK;
         end
         ST_QK: begin
            rd_addr = k_ff;
            if (out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = VAL_QUAD;
               cmd.last = (deg_ff == DEG_QUAD) && (j_ff == lm1) && (k_ff == j_ff);
               idx_in   = idx_ff + 1'b1;
               if (k_ff == j_ff) begin
                  if (j_ff == lm1) begin
                     j_in     = '0;
                     state_in = (deg_ff == DEG_QUAD) ? ST_IDLE : ST_CJ;
                  end else begin
                     j_in     = j_ff + 1'b1;
                     state_in = ST_QJ;
                  end
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         ST_CJ: begin
            rd_addr     = j_ff;
            cmd.load_xj = 1'b1;
            k_in        = '0;
            state_in    = ST_CK;
         end
         ST_CK: begin
            rd_addr      = k_ff;
            cmd.load_pjk = 1'b1;
            m_in         = '0;
            state_in     = ST_CM;
         end
         ST_CM: begin
            rd_addr = m_ff;
            if (out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = VAL_CUBE;
               cmd.last = (j_ff == lm1) && (k_ff == j_ff) && (m_ff == k_ff);
               idx_in   = idx_ff + 1'b1;
               if (m_ff == k_ff) begin
                  if (k_ff == j_ff) begin
                     if (j_ff == lm1) begin
                        state_in = ST_IDLE;
                     end else begin
                        j_in     = j_ff + 1'b1;
                        state_in = ST_CJ;
                     end
                  end else begin
                     k_in     = k_ff + 1'b1;
                     state_in = ST_CK;
                  end
               end else begin
                  m_in = m_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

`default_nettype wire

// ===== sv/pfe_datapath.sv =====
// Datapath: row element store, product registers and the result register.
`timescale 1ns / 1ps
`default_nettype none

module pfe_datapath
   import pfe_pkg::*;
#(
   parameter int MAX_ROW_LENGTH = 5
) (
   input  wire logic                        clock,
   input  wire pfe_cmd_type                 cmd,
   input  wire logic [((MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1)-1:0] wr_addr,
   input  wire logic [((MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1)-1:0] rd_addr,
   input  wire logic signed [SAMPLE_W-1:0]  req_sample,
   output logic signed [VALUE_W-1:0]        rsp_feature_value,
   output logic [FEAT_IDX_W-1:0]            rsp_feature_index,
   output logic                             rsp_last_feature
);

   logic signed [SAMPLE_W-1:0]   row_ff [MAX_ROW_LENGTH];
   logic signed [SAMPLE_W-1:0]   xj_ff;
   logic signed [2*SAMPLE_W-1:0] pjk_ff;
   logic signed [VALUE_W-1:0]    value_ff, value_in;
   logic [FEAT_IDX_W-1:0]        index_ff;
   logic                         last_ff;

   logic signed [SAMPLE_W-1:0]   rd_data;
   logic signed [2*SAMPLE_W-1:0] prod2;
   logic signed [VALUE_W-1:0]    prod3;

   assign rd_data = row_ff[rd_addr];
   assign prod2   = (2*SAMPLE_W)'(xj_ff) * (2*SAMPLE_W)'(rd_data);
   assign prod3   = VALUE_W'(pjk_ff) * VALUE_W'(rd_data);

   always_comb begin
      case (cmd.sel)
         VAL_CONST: value_in = CONST_FEATURE;
         VAL_LIN:   value_in = {{8{rd_data[SAMPLE_W-1]}}, rd_data, 24'd0};
         VAL_QUAD:  value_in = {{4{prod2[2*SAMPLE_W-1]}}, prod2, 12'd0};
         VAL_CUBE:  value_in = prod3;
         default:   value_in = CONST_FEATURE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         row_ff[wr_addr] <= req_sample;
      end
      if (cmd.load_xj) begin
         xj_ff <= rd_data;
      end
      if (cmd.load_pjk) begin
         pjk_ff <= prod2;
      end
      if (cmd.emit) begin
         value_ff <= value_in;
         index_ff <= cmd.index;
         last_ff  <= cmd.last;
      end
   end

   assign rsp_feature_value = value_ff;
   assign rsp_feature_index = index_ff;
   assign rsp_last_feature  = last_ff;

endmodule

`default_nettype wire

// ===== sv/polynomial_feature_expansion.sv =====
// Top level: polynomial feature expansion up to degree three, with APB registers.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                                             | Direction
// ---------+---------------------------------------------------+----------
// request  | req_valid, req_ready, req_sample                  | in
// response | rsp_valid, rsp_ready, rsp_feature_value,          | out
//          | rsp_feature_index, rsp_last_feature               |
// csr      | csr_psel, csr_penable, csr_pwrite, csr_paddr,     | in/out
//          | csr_pwdata, csr_prdata, csr_pready                |
//
// Sequence: an item that does not complete a row is only stored. The item that
//   completes a row starts the emission sequence: the constant feature, then
//   the linear, quadratic and cubic groups at degree three; lower degrees drop
//   the later groups. The row store has a single read port, so each j costs a
//   load of x(j) ahead of its quadratic or cubic features, and each cubic pair
//   (j,k) a load of the product x(j)x(k) ahead of its features.
// Reset: synchronous, active high; clears the sequencer, the element count and
//   the registers (degree 3, row length 5). The row store is not cleared.
// Stalls: a result waits in the output register; the sequencer holds while it
//   is not taken. New items are taken only between rows.

module polynomial_feature_expansion
   import pfe_pkg::*;
#(
   parameter int MAX_ROW_LENGTH = 5
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   // response channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [VALUE_W-1:0]       rsp_feature_value,
   output logic [FEAT_IDX_W-1:0]           rsp_feature_index,
   output logic                            rsp_last_feature,
   // configuration port
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]      csr_pwdata,
   output logic [CSR_DATA_W-1:0]           csr_prdata,
   output logic                            csr_pready
);

   localparam int IDX_W = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;

   logic [DEGREE_W-1:0]  degree_ff, degree_in;
   logic [ROW_LEN_W-1:0] row_length_ff, row_length_in;
   logic                 csr_write;
   logic                 csr_idx;

   pfe_cmd_type      cmd;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;

   // ------------------------------------------------------------------
   // Configuration registers. Word index comes from paddr[2]; the byte
   // offset bits are ignored, as usual for a 32-bit APB slave.
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[2];

   always_comb begin
      degree_in     = degree_ff;
      row_length_in = row_length_ff;
      if (csr_write) begin
         case (csr_idx)
            CSR_IDX_DEGREE:     degree_in     = csr_pwdata[DEGREE_W-1:0];
            CSR_IDX_ROW_LENGTH: row_length_in = csr_pwdata[ROW_LEN_W-1:0];
            default: begin
               degree_in     = degree_ff;
               row_length_in = row_length_ff;
            end
         endcase
      end
   end

   // Read back the addressed register, zero-extended to the bus
   always_comb begin
      case (csr_idx)
         CSR_IDX_DEGREE:     csr_prdata = CSR_DATA_W'(degree_ff);
         CSR_IDX_ROW_LENGTH: csr_prdata = CSR_DATA_W'(row_length_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff     <= DEGREE_RESET;
         row_length_ff <= ROW_LENGTH_RESET;
      end else begin
         degree_ff     <= degree_in;
         row_length_ff <= row_length_in;
      end
   end

   // ------------------------------------------------------------------
   // Controller: counts elements into the row, then walks the constant,
   // linear, quadratic and cubic groups and drives the datapath.
   // ------------------------------------------------------------------
   pfe_ctrl #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .cfg_degree     (degree_ff),
      .cfg_row_length (row_length_ff),
      .cmd            (cmd),
      .wr_addr        (wr_addr),
      .rd_addr        (rd_addr)
   );

   // ------------------------------------------------------------------
   // Datapath: row store, x(j) and x(j)x(k) registers, output register.
   // ------------------------------------------------------------------
   pfe_datapath #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
   ) u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .wr_addr           (wr_addr),
      .rd_addr           (rd_addr),
      .req_sample        (req_sample),
      .rsp_feature_value (rsp_feature_value),
      .rsp_feature_index (rsp_feature_index),
      .rsp_last_feature  (rsp_last_feature)
   );

endmodule

`default_nettype wire

// ===== sv/pfe_checker.sv =====
// Checker: port-level assertions for the feature expansion block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module pfe_checker
   import pfe_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [VALUE_W-1:0]    rsp_feature_value,
   input wire logic [FEAT_IDX_W-1:0] rsp_feature_index,
   input wire logic                  rsp_last_feature
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_feature_value)
         && $stable(rsp_feature_index) && $stable(rsp_last_feature))
      else $error("stalled result changed");

   // Features of one row come out with consecutive indexes
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_feature |=>
         !rsp_valid || (rsp_feature_index == $past(rsp_feature_index) + 1'b1))
      else $error("feature index skipped");

   // A new row starts at index zero
   a_row_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_feature |=>
         !rsp_valid || (rsp_feature_index == '0))
      else $error("row did not restart at index zero");

   // The first feature of every row is the constant one
   a_const_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_feature_index == '0) |-> rsp_feature_value == CONST_FEATURE)
      else $error("constant feature wrong");

endmodule

bind polynomial_feature_expansion pfe_checker u_pfe_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_feature_value (rsp_feature_value),
   .rsp_feature_index (rsp_feature_index),
   .rsp_last_feature  (rsp_last_feature)
);

`default_nettype wire

// ===== bench/polynomial_feature_expansion_tb.sv =====
// Testbench for the polynomial feature expansion block: directed and random rows, checked live.
`timescale 1ns / 1ps

module polynomial_feature_expansion_tb
   import pfe_pkg::*;
();

   localparam int MAX_ROW     = 5;
   localparam int SETTLE_WAIT = 16;      // cycles after the last feature before touching registers
   localparam int CYCLE_LIMIT = 400000;  // far above the slowest legal run

   // One expected feature of a row, at the block's own widths
   typedef struct packed {
      logic [VALUE_W-1:0]    value;
      logic [FEAT_IDX_W-1:0] index;
      logic                  last;
   } feature_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic signed [SAMPLE_W-1:0]   req_sample = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0]    rsp_feature_value;
   logic [FEAT_IDX_W-1:0]        rsp_feature_index;
   logic                         rsp_last_feature;
   logic                         csr_psel = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]        csr_paddr = '0;
   logic [CSR_DATA_W-1:0]        csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]        csr_prdata;
   logic                         csr_pready;

   // Shadow of the block: registers, current row and the features still owed
   logic [DEGREE_W-1:0]          cfg_degree = DEG_CUBIC;
   logic [ROW_LEN_W-1:0]         cfg_row_length = 3'd5;
   logic signed [SAMPLE_W-1:0]   row_elems [MAX_ROW];
   int                           elem_count = 0;
   feature_type                  expected_features [$];

   // Traffic shaping for the sender and the receiver, and the run counters
   int                           req_idle_pct = 0;
   int                           rsp_stall_pct = 0;
   int                           hold_left = 0;
   int                           mismatch_count = 0;
   int                           cycle_count = 0;

   polynomial_feature_expansion #(
      .MAX_ROW_LENGTH (MAX_ROW)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_feature_value (rsp_feature_value),
      .rsp_feature_index (rsp_feature_index),
      .rsp_last_feature  (rsp_last_feature),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #4 clock = ~clock;

   // Hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d features outstanding", cycle_count,
                  expected_features.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Effective row length: zero reads as one, anything above the store saturates
   function automatic int row_span();
      if (cfg_row_length == 3'd0)
         return 1;
      if (int'(cfg_row_length) > MAX_ROW)
         return MAX_ROW;
      return int'(cfg_row_length);
   endfunction

   // Store one accepted element; when it closes the row, queue the whole feature row.
   // Values: constant 2^36, linear x*2^24, quadratic x*y*2^12, cubic x*y*z, all exact.
   function automatic void take_sample(input logic signed [SAMPLE_W-1:0] s);
      int          len;
      longint      vals [$];
      longint      xj, xk, xm;
      logic [63:0] wide;
      feature_type f;
      len = row_span();
      // a row length lowered below the partial row drops what was collected
      if (elem_count >= len)
         elem_count = 0;
      row_elems[elem_count] = s;
      elem_count++;
      if (elem_count < len)
         return;
      elem_count = 0;
      vals.push_back(longint'(1) << 36);
      if (cfg_degree >= DEG_LINEAR)
         for (int j = 0; j < len; j++) begin
            xj = longint'(row_elems[j]);
            vals.push_back(xj * (longint'(1) << 24));
         end
      if (cfg_degree >= DEG_QUAD)
         for (int j = 0; j < len; j++)
            for (int k = 0; k <= j; k++) begin
               xj = longint'(row_elems[j]);
               xk = longint'(row_elems[k]);
               vals.push_back(xj * xk * 4096);
            end
      if (cfg_degree >= DEG_CUBIC)
         for (int j = 0; j < len; j++)
            for (int k = 0; k <= j; k++)
               for (int m = 0; m <= k; m++) begin
                  xj = longint'(row_elems[j]);
                  xk = longint'(row_elems[k]);
                  xm = longint'(row_elems[m]);
                  vals.push_back(xj * xk * xm);
               end
      foreach (vals[i]) begin
         wide    = vals[i];
         f.value = wide[VALUE_W-1:0];
         f.index = i[FEAT_IDX_W-1:0];
         f.last  = (i == vals.size() - 1);
         expected_features.push_back(f);
      end
   endfunction

   // Compare one taken feature against the oldest one owed
   task automatic check_feature();
      feature_type want;
      if (expected_features.size() == 0) begin
         report_mismatch("feature_index (nothing expected)", 64'(rsp_feature_index), '0);
         return;
      end
      want = expected_features.pop_front();
      if (rsp_feature_value !== want.value)
         report_mismatch("feature_value", 64'($unsigned(rsp_feature_value)), 64'(want.value));
      if (rsp_feature_index !== want.index)
         report_mismatch("feature_index", 64'(rsp_feature_index), 64'(want.index));
      if (rsp_last_feature !== want.last)
         report_mismatch("last_feature", 64'(rsp_last_feature), 64'(want.last));
   endtask

   // Receiver: check what was taken at this edge, then pick ready for the next cycle.
   // A pending hold-off forces ready low until hold_left counts down to zero.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_feature();
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Offer one element, idling first at random; valid stays up between back-to-back items
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      take_sample(s);
   endtask

   // Drop valid, wait for every owed feature, then give the block time to go idle
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_features.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // APB write followed by a read-back of the same register
   task automatic program_reg(input logic idx, input logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (idx == CSR_IDX_DEGREE) begin
         cfg_degree = data[DEGREE_W-1:0];
         want = CSR_DATA_W'(cfg_degree);
      end else begin
         cfg_row_length = data[ROW_LEN_W-1:0];
         want = CSR_DATA_W'(cfg_row_length);
      end
      // read back
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (csr_prdata !== want)
         report_mismatch(idx == CSR_IDX_DEGREE ? "degree read-back" : "row_length read-back",
                         64'(csr_prdata), 64'(want));
      // leave the bus idle before the next access
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Mix of extremes, tiny values and full-range noise
   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return SAMPLE_W'($urandom_range(31)) - 16'sd16;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Reset values, then a full cubic row of five at the field extremes
   task automatic test_reset_values();
      if (cfg_degree != DEG_CUBIC || cfg_row_length != 3'd5)
         report_mismatch("shadow reset", 64'({cfg_degree, cfg_row_length}), '0);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh0000);
      send_sample(16'sh0001);
      send_sample(16'shFFFF);
      settle();
      program_reg(CSR_IDX_DEGREE, CSR_DATA_W'(DEG_CUBIC));
      program_reg(CSR_IDX_ROW_LENGTH, 32'd5);
   endtask

   // One-element rows at every degree
   task automatic test_each_degree();
      logic [DEGREE_W-1:0] d;
      program_reg(CSR_IDX_ROW_LENGTH, 32'd1);
      for (int i = 0; i < 4; i++) begin
         d = i[DEGREE_W-1:0];
         program_reg(CSR_IDX_DEGREE, CSR_DATA_W'(d));
         send_sample(i[0] ? 16'sh7FFF : 16'sh8000);
         settle();
      end
   endtask

   // Row length zero acts as one; above the store it saturates
   task automatic test_row_length_limits();
      program_reg(CSR_IDX_DEGREE, CSR_DATA_W'(DEG_CUBIC));
      program_reg(CSR_IDX_ROW_LENGTH, 32'hFFFF_FFF8);
      send_sample(16'sh4000);
      settle();
      program_reg(CSR_IDX_ROW_LENGTH, 32'd7);
      send_sample(16'shC000);
      send_sample(16'sh1234);
      send_sample(16'shEDCB);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      settle();
   endtask

   // Lower the row length below a partial row: the partial row is dropped
   task automatic test_mid_row_change();
      program_reg(CSR_IDX_ROW_LENGTH, 32'd5);
      send_sample(16'sh1111);
      send_sample(16'sh2222);
      send_sample(16'sh3333);
      settle();
      program_reg(CSR_IDX_ROW_LENGTH, 32'd2);
      program_reg(CSR_IDX_DEGREE, CSR_DATA_W'(DEG_LINEAR));
      send_sample(16'sh5A5A);
      send_sample(16'shA5A5);
      settle();
   endtask

   // Hold the receiver off long enough to back the block up into its input,
   // then pause the sender until everything has drained
   task automatic test_output_stall();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      program_reg(CSR_IDX_DEGREE, CSR_DATA_W'(DEG_CUBIC));
      program_reg(CSR_IDX_ROW_LENGTH, 32'd5);
      hold_left = 400;
      repeat (15) send_sample(random_sample());
      settle();
      repeat (10) send_sample(random_sample());
      settle();
   endtask

   // Random settings, whole rows of random elements, now and then a partial row
   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int goal);
      int sent;
      int len;
      int count;
      sent          = 0;
      req_idle_pct  = send_pct;
      rsp_stall_pct = recv_pct;
      while (sent < goal) begin
         program_reg(CSR_IDX_DEGREE, $urandom);
         program_reg(CSR_IDX_ROW_LENGTH, $urandom);
         len   = row_span();
         count = len * $urandom_range(1, 4);
         if ($urandom_range(4) == 0)
            count += $urandom_range(1, len);
         repeat (count) send_sample(random_sample());
         sent += count;
         settle();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, receiver always ready
      test_reset_values();
      test_each_degree();
      test_row_length_limits();
      test_mid_row_change();

      // random part: sender mostly busy, then receiver mostly busy, then both flat out
      test_random_traffic(13, 81, 100);
      test_random_traffic(81, 13, 100);
      test_random_traffic(0, 0, 100);

      test_output_stall();

      settle();
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/pfe_pkg.sv
sv/pfe_ctrl.sv
sv/pfe_datapath.sv
sv/polynomial_feature_expansion.sv
sv/pfe_checker.sv
bench/polynomial_feature_expansion_tb.sv
